>>> src/lmtd_pkg.sv
`timescale 1ns / 1ps

package lmtd_pkg;

    // input request: one sample tick or an end of message
    typedef struct packed {
        logic       command;
        logic [9:0] light_level;
    } in_item_t;

    // one decoded result
    typedef struct packed {
        logic [5:0] symbol;
        logic       last;
    } out_item_t;

    // finished code handed from the front to the back
    typedef struct packed {
        logic [2:0] length;
        logic [5:0] marks;
        logic       space;
    } evt_t;

    // config register indexes
    localparam logic REG_UNIT_TICKS   = 1'b0;
    localparam logic REG_ON_THRESHOLD = 1'b1;

    // command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic [5:0] SYM_UNKNOWN = 6'd36;
    localparam logic [5:0] SYM_SPACE   = 6'd37;

    localparam logic [2:0] CODE_OVERLONG = 3'd6;

    localparam logic [15:0] UNIT_RESET      = 16'd20;
    localparam logic [9:0]  THRESHOLD_RESET = 10'd100;

    localparam int EVT_DEPTH = 4;
    localparam int EVT_PTR_W = 2;

    localparam int CODE_COUNT = 36;

    // entry = {length, dash bits}, bit i is mark i
    localparam logic [8:0] CODE_TABLE [CODE_COUNT] = '{
        {3'd2, 6'h02}, {3'd4, 6'h01}, {3'd4, 6'h05}, {3'd3, 6'h01},
        {3'd1, 6'h00}, {3'd4, 6'h04}, {3'd3, 6'h03}, {3'd4, 6'h00},
        {3'd2, 6'h00}, {3'd4, 6'h0E}, {3'd3, 6'h05}, {3'd4, 6'h02},
        {3'd2, 6'h03}, {3'd2, 6'h01}, {3'd3, 6'h07}, {3'd4, 6'h06},
        {3'd4, 6'h0B}, {3'd3, 6'h02}, {3'd3, 6'h00}, {3'd1, 6'h01},
        {3'd3, 6'h04}, {3'd4, 6'h08}, {3'd3, 6'h06}, {3'd4, 6'h09},
        {3'd4, 6'h0D}, {3'd4, 6'h03},
        {3'd5, 6'h1F}, {3'd5, 6'h1E}, {3'd5, 6'h1C}, {3'd5, 6'h18},
        {3'd5, 6'h10}, {3'd5, 6'h00}, {3'd5, 6'h01}, {3'd5, 6'h03},
        {3'd5, 6'h07}, {3'd5, 6'h0F}
    };

    function automatic logic [5:0] decode_code(input logic [2:0] length,
                                               input logic [5:0] marks);
        logic [5:0] sym;
        sym = SYM_UNKNOWN;
        if (length != 3'd0 && length < CODE_OVERLONG)
        begin
            for (int i = 0; i < CODE_COUNT; i++)
            begin
                if (CODE_TABLE[i] == {length, marks})
                begin
                    sym = 6'(i);
                end
            end
        end
        return sym;
    endfunction

endpackage

>>> src/lmtd_front.sv
`timescale 1ns / 1ps

module lmtd_front #(
    parameter int TIMER_BITS = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  lmtd_pkg::in_item_t sample,
    input  logic             cfg_write,
    input  logic             cfg_index,
    input  logic [15:0]      cfg_data,
    output logic             evt_valid,
    output lmtd_pkg::evt_t   evt
);
    import lmtd_pkg::*;

    // compare width covers the timers and seven units
    localparam int CW = (TIMER_BITS > 19) ? TIMER_BITS : 19;

    logic [15:0]           unit_reg;
    logic [9:0]            thr_reg;
    logic                  signal_on_reg, signal_on_next;
    logic [TIMER_BITS-1:0] on_timer_reg, on_timer_next;
    logic [TIMER_BITS-1:0] gap_timer_reg, gap_timer_next;
    logic [5:0]            marks_reg, marks_next;
    logic [2:0]            len_reg, len_next;

    logic [TIMER_BITS-1:0] on_inc, gap_inc;
    logic [CW-1:0]         on_cmp, gap_cmp;
    logic [CW-1:0]         unit2, unit3, unit7;
    logic                  sig_now;
    logic                  dash;

    always_comb
    begin
        on_inc  = (on_timer_reg == '1) ? on_timer_reg : on_timer_reg + TIMER_BITS'(1);
        gap_inc = (gap_timer_reg == '1) ? gap_timer_reg : gap_timer_reg + TIMER_BITS'(1);
        on_cmp  = CW'(on_inc);
        gap_cmp = CW'(gap_inc);
        unit2   = CW'({unit_reg, 1'b0});
        unit3   = CW'({unit_reg, 1'b0}) + CW'(unit_reg);
        unit7   = CW'({unit_reg, 3'b000}) - CW'(unit_reg);
        sig_now = sample.light_level < thr_reg;
        dash    = !(on_cmp < unit2);
    end

    always_comb
    begin
        signal_on_next = signal_on_reg;
        on_timer_next  = on_timer_reg;
        gap_timer_next = gap_timer_reg;
        marks_next     = marks_reg;
        len_next       = len_reg;
        evt_valid      = 1'b0;
        evt.length     = len_reg;
        evt.marks      = marks_reg;
        evt.space      = 1'b0;
        if (accept)
        begin
            if (sample.command == CMD_END)
            begin
                // flush pending code, then clear the decoder
                evt_valid      = len_reg != 3'd0;
                signal_on_next = 1'b0;
                on_timer_next  = '0;
                gap_timer_next = '0;
                marks_next     = '0;
                len_next       = '0;
            end
            else if (sig_now && !signal_on_reg)
            begin
                signal_on_next = 1'b1;
                on_timer_next  = '0;
                gap_timer_next = gap_inc;
                if (gap_cmp > unit3 && len_reg != 3'd0)
                begin
                    evt_valid  = 1'b1;
                    evt.space  = gap_cmp > unit7;
                    marks_next = '0;
                    len_next   = '0;
                end
            end
            else if (!sig_now && signal_on_reg)
            begin
                signal_on_next = 1'b0;
                on_timer_next  = '0;
                gap_timer_next = '0;
                if (len_reg < CODE_OVERLONG)
                begin
                    marks_next = marks_reg | (dash ? (6'd1 << len_reg) : 6'd0);
                    len_next   = len_reg + 3'd1;
                end
            end
            else
            begin
                on_timer_next  = on_inc;
                gap_timer_next = gap_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg      <= UNIT_RESET;
            thr_reg       <= THRESHOLD_RESET;
            signal_on_reg <= 1'b0;
            on_timer_reg  <= '0;
            gap_timer_reg <= '0;
            marks_reg     <= '0;
            len_reg       <= '0;
        end
        else
        begin
            if (cfg_write && cfg_index == REG_UNIT_TICKS)
            begin
                unit_reg <= cfg_data;
            end
            if (cfg_write && cfg_index == REG_ON_THRESHOLD)
            begin
                thr_reg <= cfg_data[9:0];
            end
            signal_on_reg <= signal_on_next;
            on_timer_reg  <= on_timer_next;
            gap_timer_reg <= gap_timer_next;
            marks_reg     <= marks_next;
            len_reg       <= len_next;
        end
    end

endmodule

>>> src/lmtd_fifo.sv
`timescale 1ns / 1ps

module lmtd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  lmtd_pkg::evt_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output lmtd_pkg::evt_t rd_data,
    output logic           empty
);
    import lmtd_pkg::*;

    evt_t                 mem [EVT_DEPTH];
    logic [EVT_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [EVT_PTR_W:0]   count_reg, count_next;

    assign full    = count_reg == (EVT_PTR_W+1)'(EVT_DEPTH);
    assign empty   = count_reg == '0;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + (EVT_PTR_W+1)'(1);
            2'b01:   count_next = count_reg - (EVT_PTR_W+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + EVT_PTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + EVT_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> src/lmtd_back.sv
`timescale 1ns / 1ps

module lmtd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                evt_empty,
    input  lmtd_pkg::evt_t      evt,
    output logic                evt_rd,
    input  logic                pop,
    output logic                empty,
    output lmtd_pkg::out_item_t result
);
    import lmtd_pkg::*;

    logic      out_valid_reg, out_valid_next;
    logic      space_pend_reg, space_pend_next;
    out_item_t out_reg, out_next;
    logic      load_ok;

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    always_comb
    begin
        load_ok         = !out_valid_reg || pop;
        out_valid_next  = out_valid_reg && !pop;
        space_pend_next = space_pend_reg;
        out_next        = out_reg;
        evt_rd          = 1'b0;
        if (load_ok)
        begin
            if (space_pend_reg)
            begin
                // word space always closes its item
                out_next.symbol = SYM_SPACE;
                out_next.last   = 1'b1;
                out_valid_next  = 1'b1;
                space_pend_next = 1'b0;
            end
            else if (!evt_empty)
            begin
                evt_rd          = 1'b1;
                out_next.symbol = decode_code(evt.length, evt.marks);
                out_next.last   = !evt.space;
                out_valid_next  = 1'b1;
                space_pend_next = evt.space;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            space_pend_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            space_pend_reg <= space_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

>>> src/light_morse_timing_decoder_core.sv
// light-keyed morse decoder, one light sample per input request
// input channel: push/full, payload sample (command, light_level); a request
//   is taken at a clock edge with push high and full low
// result channel: empty/pop, payload result (symbol, last); the oldest result
//   is shown while empty is low and leaves at an edge with pop high
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is
//   unit_ticks, index 1 is on_threshold; cfg_ready is always high, and writes
//   belong in idle periods
// throughput: one sample per cycle, full stays low while the result side keeps up;
//   a word space makes two results, drained one per cycle while pop stays high
// a finished code is written into the code queue, then decoded into the result register
// a receiver that stops popping holds the result steady; the four-entry code
//   queue then fills and raises full
// reset: timers, pending code and queues clear, unit_ticks goes to 20 and
//   on_threshold to 100
`timescale 1ns / 1ps

module light_morse_timing_decoder_core #(
    parameter int TIMER_BITS = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  lmtd_pkg::in_item_t  sample,
    output logic                empty,
    input  logic                pop,
    output lmtd_pkg::out_item_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data
);
    import lmtd_pkg::*;

    logic accept;
    logic evt_valid;
    evt_t evt_in, evt_out;
    logic evt_full, evt_empty, evt_rd;

    // config is always taken at once
    assign cfg_ready = 1'b1;

    // the front only stalls on a full code queue
    assign full   = evt_full;
    assign accept = push && !evt_full;

    // front: sample classification, edge timing and mark collection
    lmtd_front #(
        .TIMER_BITS (TIMER_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .sample    (sample),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .evt_valid (evt_valid),
        .evt       (evt_in)
    );

    // finished codes waiting for lookup
    lmtd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && evt_valid),
        .wr_data (evt_in),
        .full    (evt_full),
        .rd_en   (evt_rd),
        .rd_data (evt_out),
        .empty   (evt_empty)
    );

    // back: table lookup and result register, splits off the word space
    lmtd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_empty (evt_empty),
        .evt       (evt_out),
        .evt_rd    (evt_rd),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

>>> src/lmtd_checker.sv
`timescale 1ns / 1ps

module lmtd_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                empty,
    input logic                pop,
    input lmtd_pkg::out_item_t result
);
    import lmtd_pkg::*;

    // symbols stay in the defined range
    a_symbol_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> result.symbol <= SYM_SPACE)
        else $error("result symbol out of range");

    // a word space always closes its item
    a_space_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.symbol == SYM_SPACE) |-> result.last)
        else $error("word space not marked last");

    // a non-final character is followed right away by its word space
    a_space_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !result.last) |=> (!empty && result.symbol == SYM_SPACE))
        else $error("word space missing after character");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed while stalled");

endmodule

bind light_morse_timing_decoder_core lmtd_checker u_lmtd_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
